// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker in fsc_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked assertion with an explicit clock and reset.
`define FSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The same assertion on the usual clock and reset names.
`define FSC_CHECK(label, prop, msg) `FSC_ASSERT(label, clock, reset, prop, msg)

`endif

// ===== rtl/fsc_pkg.sv =====
package fsc_pkg;

   localparam int DATA_W        = 16;
   localparam int PC_W          = 15;
   localparam int MEM_BYTES_DEF = 65536;

   localparam logic [PC_W-1:0] SP_RESET = 15'd8704;
   localparam logic [PC_W-1:0] RP_RESET = 15'd32767;

   // Instruction class in bits 15:13 for ALU words.
   localparam logic [2:0] CLS_ALU = 3'b011;

   // ALU operation codes, bits 12:8 of an ALU word.
   localparam logic [4:0] OP_T     = 5'd0;
   localparam logic [4:0] OP_N     = 5'd1;
   localparam logic [4:0] OP_R     = 5'd2;
   localparam logic [4:0] OP_FETCH = 5'd3;
   localparam logic [4:0] OP_STORE = 5'd4;
   localparam logic [4:0] OP_ADDC  = 5'd5;
   localparam logic [4:0] OP_MUL   = 5'd6;
   localparam logic [4:0] OP_AND   = 5'd7;
   localparam logic [4:0] OP_OR    = 5'd8;
   localparam logic [4:0] OP_XOR   = 5'd9;
   localparam logic [4:0] OP_INV   = 5'd10;
   localparam logic [4:0] OP_DEC   = 5'd11;
   localparam logic [4:0] OP_ZEQ   = 5'd12;
   localparam logic [4:0] OP_EQ    = 5'd13;
   localparam logic [4:0] OP_ULT   = 5'd14;
   localparam logic [4:0] OP_LT    = 5'd15;
   localparam logic [4:0] OP_RSH   = 5'd16;
   localparam logic [4:0] OP_LSH   = 5'd17;
   localparam logic [4:0] OP_SPGET = 5'd18;
   localparam logic [4:0] OP_RPGET = 5'd19;
   localparam logic [4:0] OP_SPSET = 5'd20;
   localparam logic [4:0] OP_RPSET = 5'd21;
   localparam logic [4:0] OP_SAVE  = 5'd22;
   localparam logic [4:0] OP_EMIT  = 5'd23;
   localparam logic [4:0] OP_KEY   = 5'd24;
   localparam logic [4:0] OP_UDIV  = 5'd25;
   localparam logic [4:0] OP_SDIV  = 5'd26;
   localparam logic [4:0] OP_HALT  = 5'd27;

   localparam logic [DATA_W-1:0] DIV0_T  = 16'd10;
   localparam logic [PC_W-1:0]   DIV0_PC = 15'd1;

   typedef struct packed {
      logic              command;
      logic [PC_W-1:0]   address;
      logic [DATA_W-1:0] data;
      logic [7:0]        in_byte;
      logic              in_end;
   } req_type;

   typedef struct packed {
      logic              out_valid;
      logic [7:0]        out_byte;
      logic              input_taken;
      logic              halted;
      logic [DATA_W-1:0] top_value;
      logic [PC_W-1:0]   next_pc;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic              is_signed;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quot;
      logic [DATA_W-1:0] rem;
   } div_rsp_type;

endpackage

// ===== rtl/fsc_ram.sv =====
module fsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fsc_div.sv =====
module fsc_div (
   input  logic                clock,
   input  logic                reset,
   input  fsc_pkg::div_req_type div_req,
   output fsc_pkg::div_rsp_type div_rsp
);
   import fsc_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, done_ff, neg_q_ff, neg_r_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0] rem_ff, quo_ff, den_ff, qout_ff, rout_ff;
   logic [DATA_W-1:0] a_mag, b_mag, rem_nx, quo_nx;
   logic [DATA_W:0]   rem_sh;
   logic              fits;

   always_comb begin
      a_mag  = (div_req.is_signed && div_req.dividend[DATA_W-1]) ?
               (DATA_W'(0) - div_req.dividend) : div_req.dividend;
      b_mag  = (div_req.is_signed && div_req.divisor[DATA_W-1]) ?
               (DATA_W'(0) - div_req.divisor) : div_req.divisor;
      // One restoring step: bring down the next dividend bit and try the divisor.
      rem_sh = {rem_ff, quo_ff[DATA_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_nx = fits ? DATA_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DATA_W-1:0];
      quo_nx = {quo_ff[DATA_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= '0;
            rem_ff   <= '0;
            quo_ff   <= a_mag;
            den_ff   <= b_mag;
            neg_q_ff <= div_req.is_signed &&
                        (div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1]);
            neg_r_ff <= div_req.is_signed && div_req.dividend[DATA_W-1];
         end else if (busy_ff) begin
            rem_ff <= rem_nx;
            quo_ff <= quo_nx;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               qout_ff <= neg_q_ff ? (DATA_W'(0) - quo_nx) : quo_nx;
               rout_ff <= neg_r_ff ? (DATA_W'(0) - rem_nx) : rem_nx;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = qout_ff;
   assign div_rsp.rem  = rout_ff;

endmodule

// ===== rtl/forth_stack_cpu_step.sv =====
//  Channel | Direction | Ports                          | Beat
//  req     | in        | req_valid, req_stall, req_data | one command
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data | one result per command
//
//  A memory write is done from idle; a literal, call or jump ends in the fetch state, a
//  0branch after one stack read, an ALU word after reading N, R and M, executing and the
//  copy states; a store adds a write and a read, a divide waits on the iterative divider.
//  Reset is synchronous and active high; it clears pc and T and resets the stack pointers.
//  Memory contents are not cleared. A stalled result is held in the output
//  register and the next command is taken as soon as that result leaves.
module forth_stack_cpu_step #(
   parameter int MEM_BYTES = fsc_pkg::MEM_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fsc_pkg::rsp_type rsp_data
);
   import fsc_pkg::*;

   localparam int MEM_WORDS = MEM_BYTES / 2;
   localparam int AW        = $clog2(MEM_WORDS);

   // The sequencer walks one instruction through fetch, operand reads, execute
   // and stack write-back, touching the memory at most once per cycle.
   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_ZB, S_RDN, S_RDR, S_RDM, S_EXEC, S_DIV,
      S_A4W, S_A4R, S_A4C, S_CPR, S_CPS
   } state_type;

   state_type         state_ff;
   logic [PC_W-1:0]   pc_ff, sp_ff, rp_ff;
   logic [DATA_W-1:0] t_ff;
   logic [DATA_W-1:0] ins_ff, n_ff, r_ff, m_ff;
   req_type           req_ff;

   // Results of the execute stage, waiting for the write-back cycles.
   logic [DATA_W-1:0] tres_ff, neff_ff, teff_ff;
   logic [PC_W-1:0]   pcn_ff, spn_ff, rpn_ff;
   logic              ov_ff, tk_ff, halt_ff;
   logic [7:0]        ob_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              accept;
   logic [PC_W-1:0]   pc_inc;
   logic [DATA_W-1:0] rd_data;

   logic              mem_we, mem_re;
   logic [PC_W-1:0]   mem_wa, mem_ra;
   logic [DATA_W-1:0] mem_wd;

   logic [4:0]          op;
   logic [DATA_W:0]     sum;
   logic [2*DATA_W-1:0] prod;
   logic [DATA_W-1:0]   x_t, x_n, x_teff;
   logic [PC_W-1:0]     x_pc, x_sp, x_rp, x_spn, x_rpn;
   logic                x_ov, x_tk, x_halt, x_wr, x_div;
   logic [7:0]          x_ob;
   logic [DATA_W-1:0]   fin_t;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // A new command enters only when the sequencer is idle and the output
   // register is empty or emptying in this cycle.
   assign req_stall = !(state_ff == S_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign pc_inc    = pc_ff + PC_W'(1);

   fsc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa[AW-1:0]),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra[AW-1:0]),
      .rd_data (rd_data)
   );

   fsc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Execute stage: every ALU operation works on the registered operands.
   // T is the old top, N the word under it, R the return-stack top and M the
   // word addressed by T.
   always_comb begin
      op     = ins_ff[12:8];
      sum    = {1'b0, t_ff} + {1'b0, n_ff};
      prod   = t_ff * n_ff;
      x_t    = t_ff;
      x_n    = n_ff;
      x_teff = t_ff;
      x_pc   = ins_ff[4] ? r_ff[DATA_W-1:1] : pc_inc;
      x_sp   = sp_ff;
      x_rp   = rp_ff;
      x_ov   = 1'b0;
      x_ob   = 8'd0;
      x_tk   = 1'b0;
      x_halt = 1'b0;
      x_wr   = 1'b0;
      x_div  = 1'b0;
      unique case (op)
         OP_N:     x_t = n_ff;
         OP_R:     x_t = r_ff;
         OP_FETCH: x_t = m_ff;
         OP_STORE: x_sp = sp_ff - PC_W'(1);
         OP_ADDC: begin
            x_t  = DATA_W'(sum[DATA_W]);
            x_n  = sum[DATA_W-1:0];
            x_wr = 1'b1;
         end
         OP_MUL: begin
            x_t  = prod[2*DATA_W-1:DATA_W];
            x_n  = prod[DATA_W-1:0];
            x_wr = 1'b1;
         end
         OP_AND:   x_t = t_ff & n_ff;
         OP_OR:    x_t = t_ff | n_ff;
         OP_XOR:   x_t = t_ff ^ n_ff;
         OP_INV:   x_t = ~t_ff;
         OP_DEC:   x_t = t_ff - DATA_W'(1);
         OP_ZEQ:   x_t = {DATA_W{t_ff == '0}};
         OP_EQ:    x_t = {DATA_W{t_ff == n_ff}};
         OP_ULT:   x_t = {DATA_W{n_ff < t_ff}};
         OP_LT:    x_t = {DATA_W{$signed(n_ff) < $signed(t_ff)}};
         OP_RSH:   x_t = (t_ff[DATA_W-1:4] == '0) ? (n_ff >> t_ff[3:0]) : '0;
         OP_LSH:   x_t = (t_ff[DATA_W-1:4] == '0) ? (n_ff << t_ff[3:0]) : '0;
         OP_SPGET: x_t = {sp_ff, 1'b0};
         OP_RPGET: x_t = {rp_ff, 1'b0};
         OP_SPSET: x_sp = t_ff[DATA_W-1:1];
         OP_RPSET: begin
            x_rp = t_ff[DATA_W-1:1];
            x_t  = n_ff;
         end
         OP_SAVE:  x_t = '1;
         OP_EMIT: begin
            x_ov = 1'b1;
            x_ob = t_ff[7:0];
            x_t  = {8'd0, t_ff[7:0]};
         end
         OP_KEY: begin
            x_tk = 1'b1;
            x_t  = req_ff.in_end ? '1 : {8'd0, req_ff.in_byte};
         end
         OP_UDIV, OP_SDIV: begin
            // Division by zero restarts at address 1 with ten on top.
            if (t_ff == '0) begin
               x_pc   = DIV0_PC;
               x_t    = DIV0_T;
               x_n    = DIV0_T;
               x_teff = DIV0_T;
            end else begin
               x_div = 1'b1;
            end
         end
         OP_HALT:  x_halt = 1'b1;
         default: ;
      endcase
      // Stack deltas are two-bit signed fields.
      x_spn = x_sp + {{(PC_W-2){ins_ff[1]}}, ins_ff[1:0]};
      x_rpn = x_rp - {{(PC_W-2){ins_ff[3]}}, ins_ff[3:2]};
   end

   assign div_req.start     = (state_ff == S_EXEC) && x_div;
   assign div_req.is_signed = (op == OP_SDIV);
   assign div_req.dividend  = n_ff;
   assign div_req.divisor   = t_ff;

   // The copy bit for N overrides T; a halt leaves T alone.
   assign fin_t = halt_ff ? t_ff : (ins_ff[5] ? neff_ff : tres_ff);

   // Memory port: one read or one write per cycle, chosen by the state.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !req_data.command) begin
               mem_we = 1'b1;
               mem_wa = req_data.address;
               mem_wd = req_data.data;
            end else if (accept) begin
               mem_re = 1'b1;
               mem_ra = pc_ff;
            end
         end
         S_FETCH: begin
            priority if (rd_data[15]) begin
               // A literal pushes the old top.
               mem_we = 1'b1;
               mem_wa = sp_ff + PC_W'(1);
               mem_wd = t_ff;
            end else if (rd_data[15:13] == CLS_ALU) begin
               mem_re = 1'b1;
               mem_ra = sp_ff;
            end else if (rd_data[14]) begin
               // A call pushes the byte address of the next instruction.
               mem_we = 1'b1;
               mem_wa = rp_ff - PC_W'(1);
               mem_wd = {pc_inc, 1'b0};
            end else if (rd_data[13]) begin
               mem_re = 1'b1;
               mem_ra = sp_ff;
            end else begin
               mem_re = 1'b0;
            end
         end
         S_RDN: begin
            mem_re = 1'b1;
            mem_ra = rp_ff;
         end
         S_RDR: begin
            mem_re = 1'b1;
            mem_ra = t_ff[DATA_W-1:1];
         end
         S_EXEC: begin
            if (x_wr) begin
               mem_we = 1'b1;
               mem_wa = sp_ff;
               mem_wd = x_n;
            end
         end
         S_A4W: begin
            mem_we = 1'b1;
            mem_wa = t_ff[DATA_W-1:1];
            mem_wd = n_ff;
         end
         S_A4R: begin
            mem_re = 1'b1;
            mem_ra = sp_ff - PC_W'(1);
         end
         S_CPR: begin
            if (ins_ff[6] && !halt_ff) begin
               mem_we = 1'b1;
               mem_wa = rpn_ff;
               mem_wd = teff_ff;
            end
         end
         S_CPS: begin
            if (ins_ff[7] && !halt_ff) begin
               mem_we = 1'b1;
               mem_wa = spn_ff;
               mem_wd = teff_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         t_ff         <= '0;
         sp_ff        <= SP_RESET;
         rp_ff        <= RP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  if (!req_data.command) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{out_valid: 1'b0, out_byte: 8'd0,
                                       input_taken: 1'b0, halted: 1'b0,
                                       top_value: t_ff, next_pc: pc_ff};
                  end else begin
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               ins_ff <= rd_data;
               priority if (rd_data[15]) begin
                  sp_ff        <= sp_ff + PC_W'(1);
                  t_ff         <= {1'b0, rd_data[14:0]};
                  pc_ff        <= pc_inc;
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{out_valid: 1'b0, out_byte: 8'd0,
                                    input_taken: 1'b0, halted: 1'b0,
                                    top_value: {1'b0, rd_data[14:0]}, next_pc: pc_inc};
                  state_ff     <= S_IDLE;
               end else if (rd_data[15:13] == CLS_ALU) begin
                  state_ff <= S_RDN;
               end else if (rd_data[14]) begin
                  rp_ff        <= rp_ff - PC_W'(1);
                  pc_ff        <= {2'b00, rd_data[12:0]};
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{out_valid: 1'b0, out_byte: 8'd0,
                                    input_taken: 1'b0, halted: 1'b0,
                                    top_value: t_ff, next_pc: {2'b00, rd_data[12:0]}};
                  state_ff     <= S_IDLE;
               end else if (rd_data[13]) begin
                  state_ff <= S_ZB;
               end else begin
                  pc_ff        <= {2'b00, rd_data[12:0]};
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{out_valid: 1'b0, out_byte: 8'd0,
                                    input_taken: 1'b0, halted: 1'b0,
                                    top_value: t_ff, next_pc: {2'b00, rd_data[12:0]}};
                  state_ff     <= S_IDLE;
               end
            end
            S_ZB: begin
               // The branch tests the old top; the popped word becomes T.
               pc_ff        <= (t_ff == '0) ? {2'b00, ins_ff[12:0]} : pc_inc;
               t_ff         <= rd_data;
               sp_ff        <= sp_ff - PC_W'(1);
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{out_valid: 1'b0, out_byte: 8'd0,
                                 input_taken: 1'b0, halted: 1'b0, top_value: rd_data,
                                 next_pc: (t_ff == '0) ? {2'b00, ins_ff[12:0]} : pc_inc};
               state_ff     <= S_IDLE;
            end
            S_RDN: begin
               n_ff     <= rd_data;
               state_ff <= S_RDR;
            end
            S_RDR: begin
               r_ff     <= rd_data;
               state_ff <= S_RDM;
            end
            S_RDM: begin
               m_ff     <= rd_data;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               tres_ff <= x_t;
               neff_ff <= x_n;
               teff_ff <= x_teff;
               pcn_ff  <= x_pc;
               spn_ff  <= x_spn;
               rpn_ff  <= x_rpn;
               ov_ff   <= x_ov;
               ob_ff   <= x_ob;
               tk_ff   <= x_tk;
               halt_ff <= x_halt;
               priority if (x_div) begin
                  state_ff <= S_DIV;
               end else if (op == OP_STORE) begin
                  state_ff <= S_A4W;
               end else begin
                  state_ff <= S_CPR;
               end
            end
            S_DIV: begin
               // The remainder replaces both N and the old top for the copy bits.
               if (div_rsp.done) begin
                  tres_ff  <= div_rsp.quot;
                  neff_ff  <= div_rsp.rem;
                  teff_ff  <= div_rsp.rem;
                  state_ff <= S_CPR;
               end
            end
            S_A4W: state_ff <= S_A4R;
            S_A4R: state_ff <= S_A4C;
            S_A4C: begin
               // The store has landed, so the new top is read after it.
               tres_ff  <= rd_data;
               state_ff <= S_CPR;
            end
            S_CPR: state_ff <= S_CPS;
            S_CPS: begin
               pc_ff <= pcn_ff;
               if (!halt_ff) begin
                  sp_ff <= spn_ff;
                  rp_ff <= rpn_ff;
                  t_ff  <= fin_t;
               end
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{out_valid: ov_ff, out_byte: ob_ff,
                                 input_taken: tk_ff, halted: halt_ff,
                                 top_value: fin_t, next_pc: pcn_ff};
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/fsc_check.sv =====
`include "assert_macros.svh"

module fsc_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fsc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fsc_pkg::rsp_type rsp_data
);

   `FSC_CHECK(a_stall_back, rsp_valid && rsp_stall |-> req_stall, "command taken while result held")
   `FSC_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled beat changed")
   `FSC_CHECK(a_write_fast, req_valid && !req_stall && !req_data.command |=> rsp_valid, "memory write result late")
   `FSC_CHECK(a_io_excl, rsp_valid |-> !(rsp_data.out_valid && rsp_data.halted), "emit and halt together")
   `FSC_CHECK(a_byte_zero, rsp_valid && !rsp_data.out_valid |-> rsp_data.out_byte == 8'd0, "stray out byte")

endmodule

bind forth_stack_cpu_step fsc_check u_fsc_check (.*);
